@@ rtl/core/dfs_timestamp_engine_macros.svh @@
// ----------------------------------------------------------------------------
// DFS timestamp engine assertion macros
// Assertion wrappers shared by the engine; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef DFS_TIMESTAMP_ENGINE_MACROS_SVH
`define DFS_TIMESTAMP_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DFS_TE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfs_timestamp_engine: same-cycle check failed");

`define DFS_TE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfs_timestamp_engine: next-cycle check failed");

`else

`define DFS_TE_ASSERT_SAME(lbl, ante, cons)

`define DFS_TE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/dfs_te_pkg.sv @@
// ----------------------------------------------------------------------------
// DFS timestamp engine package
// Request and result types, opcodes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_te_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] from_vertex;
        logic [5:0] to_vertex;
    } req_item_t;

    typedef struct packed {
        logic [5:0] vertex;
        logic [6:0] discover_time;
        logic [6:0] finish_time;
        logic [5:0] parent_vertex;
        logic       last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        DSEL_SOURCE,
        DSEL_SCAN,
        DSEL_CHILD
    } disc_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_START,
        ST_SCAN,
        ST_ADJ_RD,
        ST_EVAL,
        ST_POP,
        ST_OUT_RD,
        ST_OUT_LD
    } ctrl_state_t;

    typedef struct packed {
        logic      latch;
        logic      clear_adj;
        logic      adj_rd;
        logic      adj_rd_top;
        logic      adj_wr;
        logic      run_init;
        logic      disc;
        disc_sel_t disc_sel;
        logic      pick_scan;
        logic      finish;
        logic      pop_top;
        logic      out_start;
        logic      out_rd;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       add_ok;
        logic       n_zero;
        logic       src_ok;
        logic       found;
        logic       stack_last;
        logic       out_free;
        logic       out_last;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/dfs_te_ctrl.sv @@
// ----------------------------------------------------------------------------
// DFS timestamp engine controller
// Sequences edge loads, the depth-first walk and the result sweep by issuing
// commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_te_ctrl
    import dfs_te_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (sts.op)
                    OP_ADD:   state_next = sts.add_ok ? ST_ADD_RD : ST_IDLE;
                    OP_RUN:   state_next = ST_START;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: state_next = ST_IDLE;
            ST_START:
            begin
                priority if (sts.n_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.src_ok)
                begin
                    state_next = ST_ADJ_RD;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:   state_next = sts.found ? ST_ADJ_RD : ST_OUT_RD;
            ST_ADJ_RD: state_next = ST_EVAL;
            ST_EVAL:
            begin
                priority if (sts.found)
                begin
                    state_next = ST_ADJ_RD;
                end
                else if (sts.stack_last)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:    state_next = ST_ADJ_RD;
            ST_OUT_RD: state_next = ST_OUT_LD;
            ST_OUT_LD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_OUT_RD;
                end
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.disc_sel = DSEL_SOURCE;
        req_stall    = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch = req_valid;
            end
            ST_DECODE:
            begin
                cmd.clear_adj = (sts.op == OP_CLEAR);
                cmd.run_init  = (sts.op == OP_RUN);
            end
            ST_ADD_RD:
            begin
                cmd.adj_rd = 1'b1;
            end
            ST_ADD_WR:
            begin
                cmd.adj_wr = 1'b1;
            end
            ST_START:
            begin
                cmd.disc     = !sts.n_zero && sts.src_ok;
                cmd.disc_sel = DSEL_SOURCE;
            end
            ST_SCAN:
            begin
                cmd.pick_scan = 1'b1;
                cmd.disc      = sts.found;
                cmd.disc_sel  = DSEL_SCAN;
                cmd.out_start = !sts.found;
            end
            ST_ADJ_RD:
            begin
                cmd.adj_rd     = 1'b1;
                cmd.adj_rd_top = 1'b1;
            end
            ST_EVAL:
            begin
                cmd.disc     = sts.found;
                cmd.disc_sel = DSEL_CHILD;
                cmd.finish   = !sts.found;
            end
            ST_POP:
            begin
                cmd.pop_top = 1'b1;
            end
            ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
            end
            ST_OUT_LD:
            begin
                cmd.out_load = sts.out_free;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/dfs_te_dp.sv @@
// ----------------------------------------------------------------------------
// DFS timestamp engine datapath
// Adjacency memory, visited vector, explicit stack, time counter, time and
// parent stores, neighbor priority encoder and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_te_dp
    import dfs_te_pkg::*;
#(
    parameter int MAX_VERTICES = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire req_item_t  req_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [5:0] cfg_wr_data,
    input  wire logic       rsp_stall,
    output logic            rsp_valid,
    output rsp_item_t       rsp_data,
    input  wire dp_cmd_t    cmd,
    output dp_sts_t         sts
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [6:0]              disc_mem [MAX_VERTICES];
    logic [5:0]              par_mem [MAX_VERTICES];
    logic [6:0]              fin_mem [MAX_VERTICES];
    logic [5:0]              stack_mem [MAX_VERTICES];

    req_item_t               item_reg;
    logic [MAX_VERTICES-1:0] adj_q_reg;
    logic                    adj_qv_reg;
    logic [5:0]              stack_q_reg;
    logic [6:0]              disc_q_reg;
    logic [5:0]              par_q_reg;
    logic [6:0]              fin_q_reg;
    rsp_item_t               rsp_data_reg;

    logic [5:0]              num_vertices_reg, num_vertices_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [6:0]              time_reg, time_next;
    logic [NW-1:0]           sp_reg, sp_next;
    logic [5:0]              top_reg, top_next;
    logic [5:0]              idx_reg, idx_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic [5:0]              from_m1, to_m1, top_m1, idx_m1, disc_m1;
    logic [IW-1:0]           adj_addr;
    logic [NW-1:0]           sp_m2, n_sat;
    logic [6:0]              time_inc;
    logic [5:0]              disc_vertex, disc_parent, enc_vertex;
    logic [MAX_VERTICES-1:0] nmask, white, child, enc_in, adj_wr_data, one_hot;
    logic [IW-1:0]           enc_idx;
    logic                    enc_found;

    assign from_m1  = item_reg.from_vertex - 6'd1;
    assign to_m1    = item_reg.to_vertex - 6'd1;
    assign top_m1   = top_reg - 6'd1;
    assign idx_m1   = idx_reg - 6'd1;
    assign disc_m1  = disc_vertex - 6'd1;
    assign adj_addr = cmd.adj_rd_top ? top_m1[IW-1:0] : from_m1[IW-1:0];
    assign sp_m2    = sp_reg - NW'(2);
    assign time_inc = time_reg + 7'd1;
    assign one_hot  = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    assign n_sat    = (7'(num_vertices_reg) > 7'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                                : NW'(num_vertices_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            nmask[i] = (NW'(i) < n_reg);
        end
    end

    assign white       = ~visited_reg & nmask;
    assign child       = (adj_qv_reg ? adj_q_reg : '0) & white;
    assign enc_in      = cmd.pick_scan ? white : child;
    assign adj_wr_data = (adj_qv_reg ? adj_q_reg : '0) | (one_hot << to_m1[IW-1:0]);

    always_comb
    begin
        enc_found = 1'b0;
        enc_idx   = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (enc_in[i])
            begin
                enc_found = 1'b1;
                enc_idx   = IW'(i);
            end
        end
    end

    assign enc_vertex = 6'(enc_idx) + 6'd1;

    always_comb
    begin
        unique case (cmd.disc_sel)
            DSEL_SOURCE:
            begin
                disc_vertex = item_reg.from_vertex;
                disc_parent = 6'd0;
            end
            DSEL_SCAN:
            begin
                disc_vertex = enc_vertex;
                disc_parent = 6'd0;
            end
            DSEL_CHILD:
            begin
                disc_vertex = enc_vertex;
                disc_parent = top_reg;
            end
            default:
            begin
                disc_vertex = enc_vertex;
                disc_parent = 6'd0;
            end
        endcase
    end

    assign sts.op         = item_reg.opcode;
    assign sts.add_ok     = (item_reg.from_vertex != 6'd0) && (item_reg.to_vertex != 6'd0) &&
                            (7'(item_reg.from_vertex) <= 7'(MAX_VERTICES)) &&
                            (7'(item_reg.to_vertex) <= 7'(MAX_VERTICES));
    assign sts.n_zero     = (n_reg == '0);
    assign sts.src_ok     = (item_reg.from_vertex != 6'd0) &&
                            (7'(item_reg.from_vertex) <= 7'(n_reg));
    assign sts.found      = enc_found;
    assign sts.stack_last = (sp_reg == NW'(1));
    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;
    assign sts.out_last   = (7'(idx_reg) == 7'(n_reg));

    always_comb
    begin
        num_vertices_next = cfg_wr_en ? cfg_wr_data : num_vertices_reg;
        n_next            = cmd.run_init ? n_sat : n_reg;

        time_next = time_reg;
        sp_next   = sp_reg;
        priority if (cmd.run_init)
        begin
            time_next = 7'd0;
            sp_next   = '0;
        end
        else if (cmd.disc)
        begin
            time_next = time_inc;
            sp_next   = sp_reg + NW'(1);
        end
        else if (cmd.finish)
        begin
            time_next = time_inc;
            sp_next   = sp_reg - NW'(1);
        end

        top_next = top_reg;
        priority if (cmd.disc)
        begin
            top_next = disc_vertex;
        end
        else if (cmd.pop_top)
        begin
            top_next = stack_q_reg;
        end

        visited_next = visited_reg;
        priority if (cmd.run_init)
        begin
            visited_next = '0;
        end
        else if (cmd.disc)
        begin
            visited_next = visited_reg | (one_hot << disc_m1[IW-1:0]);
        end

        row_valid_next = row_valid_reg;
        priority if (cmd.clear_adj)
        begin
            row_valid_next = '0;
        end
        else if (cmd.adj_wr)
        begin
            row_valid_next = row_valid_reg | (one_hot << from_m1[IW-1:0]);
        end

        idx_next = idx_reg;
        priority if (cmd.out_start)
        begin
            idx_next = 6'd1;
        end
        else if (cmd.out_load)
        begin
            idx_next = idx_reg + 6'd1;
        end

        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= 6'd32;
            n_reg            <= '0;
            time_reg         <= 7'd0;
            sp_reg           <= '0;
            top_reg          <= 6'd0;
            idx_reg          <= 6'd0;
            visited_reg      <= '0;
            row_valid_reg    <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            num_vertices_reg <= num_vertices_next;
            n_reg            <= n_next;
            time_reg         <= time_next;
            sp_reg           <= sp_next;
            top_reg          <= top_next;
            idx_reg          <= idx_next;
            visited_reg      <= visited_next;
            row_valid_reg    <= row_valid_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= req_data;
        end
        if (cmd.adj_rd)
        begin
            adj_q_reg  <= adj_mem[adj_addr];
            adj_qv_reg <= row_valid_reg[adj_addr];
        end
        if (cmd.adj_wr)
        begin
            adj_mem[from_m1[IW-1:0]] <= adj_wr_data;
        end
        if (cmd.disc)
        begin
            disc_mem[disc_m1[IW-1:0]]  <= time_inc;
            par_mem[disc_m1[IW-1:0]]   <= disc_parent;
            stack_mem[sp_reg[IW-1:0]]  <= disc_vertex;
        end
        if (cmd.finish)
        begin
            fin_mem[top_m1[IW-1:0]] <= time_inc;
            stack_q_reg             <= stack_mem[sp_m2[IW-1:0]];
        end
        if (cmd.out_rd)
        begin
            disc_q_reg <= disc_mem[idx_m1[IW-1:0]];
            par_q_reg  <= par_mem[idx_m1[IW-1:0]];
            fin_q_reg  <= fin_mem[idx_m1[IW-1:0]];
        end
        if (cmd.out_load)
        begin
            rsp_data_reg.vertex        <= idx_reg;
            rsp_data_reg.discover_time <= disc_q_reg;
            rsp_data_reg.finish_time   <= fin_q_reg;
            rsp_data_reg.parent_vertex <= par_q_reg;
            rsp_data_reg.last          <= sts.out_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/dfs_timestamp_engine.sv @@
// ----------------------------------------------------------------------------
// DFS timestamp engine
// Depth-first search over a directed graph held as a bit adjacency matrix.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_stall stays high until it is done.
// A clear is done in the decode step. An edge add reads and then writes back
// one adjacency row in the row memory, and an add with a vertex out of range
// is dropped at decode. In a run, each discovery costs the discovering step
// and an adjacency row read, each finish of a vertex below a tree root the
// finish step, a stack pop and a row read, and each finish of a tree root the
// finish step alone; when the source is out of range the run begins with a
// scan step. A closing scan then starts the result sweep, in which each
// result takes a store read and a load of the result register, and the load
// waits while rsp_stall holds the previous result. Results come out in vertex
// order, last set on vertex n; a run with zero vertices in use gives none.
// The user must write num_vertices through cfg_wr_en and cfg_wr_data only
// while the engine is idle; the engine itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_timestamp_engine_macros.svh"

module dfs_timestamp_engine
    import dfs_te_pkg::*;
#(
    parameter int MAX_VERTICES = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_item_t  req_data,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_item_t       rsp_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [5:0] cfg_wr_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    dfs_te_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    dfs_te_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_data    (req_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .rsp_data    (rsp_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    `DFS_TE_ASSERT_NEXT(a_busy_after_request, req_valid && !req_stall, req_stall)
    `DFS_TE_ASSERT_SAME(a_load_only_when_free, cmd.out_load, sts.out_free)
    `DFS_TE_ASSERT_NEXT(a_add_read_then_write, cmd.adj_rd && !cmd.adj_rd_top, cmd.adj_wr)

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// DFS timestamp engine testbench
// Loads directed graphs edge by edge, runs depth-first searches under several
// vertex counts, and checks every discovery/finish/parent result against a
// behavioral search kept in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import dfs_te_pkg::*;

    localparam int         MAX_V     = 32;
    localparam int         SETTLE    = 16;
    localparam int         RAND_REQS = 120;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        WHITE,
        GREY,
        BLACK
    } colour_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       req_valid   = 1'b0;
    logic       req_stall;
    req_item_t  req_data    = '0;
    logic       rsp_valid;
    logic       rsp_stall   = 1'b0;
    rsp_item_t  rsp_data;
    logic       cfg_wr_en   = 1'b0;
    logic [5:0] cfg_wr_data = 6'd0;

    logic [31:0] edge_rows [1:MAX_V];
    logic [5:0]  vertex_count_reg;
    rsp_item_t   pending_results [$];
    rsp_item_t   want;

    int  error_count     = 0;
    int  request_count   = 0;
    int  search_count    = 0;
    int  results_checked = 0;
    int  setting_count   = 0;
    int  rsp_hold        = 0;
    bit  req_idle_on     = 1'b1;
    bit  rsp_idle_on     = 1'b1;

    dfs_timestamp_engine #(
        .MAX_VERTICES(MAX_V)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_search(input logic [5:0] source);
        int          n;
        int          sp;
        int          stamp;
        int          root;
        int          top;
        int          nxt;
        int          stack [0:MAX_V-1];
        colour_t     colour [1:MAX_V];
        logic [6:0]  disc [1:MAX_V];
        logic [6:0]  fin [1:MAX_V];
        logic [5:0]  par [1:MAX_V];
        rsp_item_t   item;
        n = (vertex_count_reg > MAX_V) ? MAX_V : int'(vertex_count_reg);
        stamp = 0;
        for (int v = 1; v <= MAX_V; v++)
        begin
            colour[v] = WHITE;
            par[v] = 6'd0;
            disc[v] = 7'd0;
            fin[v] = 7'd0;
        end
        for (int k = 0; k <= n; k++)
        begin
            root = (k == 0) ? int'(source) : k;
            if (root >= 1 && root <= n && colour[root] == WHITE)
            begin
                stamp++;
                colour[root] = GREY;
                disc[root] = stamp[6:0];
                stack[0] = root;
                sp = 1;
                while (sp > 0)
                begin
                    top = stack[sp-1];
                    nxt = 0;
                    for (int i = n; i >= 1; i--)
                        if (edge_rows[top][i-1] && colour[i] == WHITE)
                            nxt = i;
                    stamp++;
                    if (nxt != 0)
                    begin
                        par[nxt] = top[5:0];
                        colour[nxt] = GREY;
                        disc[nxt] = stamp[6:0];
                        stack[sp] = nxt;
                        sp++;
                    end
                    else
                    begin
                        colour[top] = BLACK;
                        fin[top] = stamp[6:0];
                        sp--;
                    end
                end
            end
        end
        for (int v = 1; v <= n; v++)
        begin
            item.vertex        = v[5:0];
            item.discover_time = disc[v];
            item.finish_time   = fin[v];
            item.parent_vertex = par[v];
            item.last          = (v == n);
            pending_results.push_back(item);
        end
    endtask

    task automatic predict_request(input req_item_t r);
        case (r.opcode)
            OP_ADD:
                if (r.from_vertex >= 1 && r.from_vertex <= MAX_V &&
                    r.to_vertex >= 1 && r.to_vertex <= MAX_V)
                    edge_rows[r.from_vertex][r.to_vertex - 1] = 1'b1;
            OP_CLEAR:
                for (int v = 1; v <= MAX_V; v++)
                    edge_rows[v] = '0;
            OP_RUN:
                predict_search(r.from_vertex);
            default: ;
        endcase
    endtask

    // call at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic [1:0] op, input logic [5:0] a,
                                input logic [5:0] b);
        req_item_t r;
        int        gap;
        r.opcode      = op;
        r.from_vertex = a;
        r.to_vertex   = b;
        gap = req_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        predict_request(r);
        request_count++;
        if (op == OP_RUN)
            search_count++;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic drain(input int extra);
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [5:0] value);
        drain(SETTLE);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        vertex_count_reg = value;
        setting_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result vertex %0d disc %0d fin %0d parent %0d",
                             $time, rsp_data.vertex, rsp_data.discover_time,
                             rsp_data.finish_time, rsp_data.parent_vertex);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (rsp_data !== want)
                    begin
                        error_count++;
                        $display("%0t: expected vertex %0d disc %0d fin %0d parent %0d last %0b",
                                 $time, want.vertex, want.discover_time,
                                 want.finish_time, want.parent_vertex, want.last);
                        $display("%0t: actual   vertex %0d disc %0d fin %0d parent %0d last %0b",
                                 $time, rsp_data.vertex, rsp_data.discover_time,
                                 rsp_data.finish_time, rsp_data.parent_vertex,
                                 rsp_data.last);
                    end
                end
                rsp_hold = rsp_idle_on ? $urandom_range(0, 7) : 0;
            end
            else if (rsp_hold > 0)
                rsp_hold--;
            rsp_stall <= (rsp_hold != 0);
        end
    end

    task automatic test_edge_cases();
        send_request(OP_RUN, 6'd1, 6'd0);
        send_request(OP_ADD, 6'd1, 6'd32);
        send_request(OP_ADD, 6'd32, 6'd1);
        send_request(OP_ADD, 6'd32, 6'd32);
        send_request(OP_ADD, 6'd1, 6'd2);
        send_request(OP_ADD, 6'd2, 6'd3);
        send_request(OP_ADD, 6'd3, 6'd1);
        send_request(OP_ADD, 6'd0, 6'd5);
        send_request(OP_ADD, 6'd5, 6'd0);
        send_request(OP_ADD, 6'd33, 6'd1);
        send_request(OP_ADD, 6'd63, 6'd63);
        send_request(OP_UNUSED, 6'd42, 6'd21);
        send_request(OP_UNUSED, 6'd21, 6'd42);
        send_request(OP_RUN, 6'd32, 6'd63);
        send_request(OP_RUN, 6'd0, 6'd0);
        send_request(OP_RUN, 6'd63, 6'd0);
        send_request(OP_CLEAR, 6'd63, 6'd63);
        send_request(OP_ADD, 6'd2, 6'd1);
        send_request(OP_RUN, 6'd2, 6'd0);
    endtask

    task automatic test_vertex_counts();
        write_vertex_count(6'd1);
        send_request(OP_RUN, 6'd1, 6'd0);
        write_vertex_count(6'd0);
        send_request(OP_RUN, 6'd0, 6'd0);
        write_vertex_count(6'd63);
        send_request(OP_RUN, 6'd63, 6'd0);
        write_vertex_count(6'd5);
        send_request(OP_ADD, 6'd5, 6'd7);
        send_request(OP_ADD, 6'd4, 6'd5);
        send_request(OP_RUN, 6'd7, 6'd0);
        write_vertex_count(6'd33);
        send_request(OP_RUN, 6'd4, 6'd0);
    endtask

    task automatic test_random_graphs();
        int         stop_at;
        int         sel;
        int         n_eff;
        int         edges;
        int         phase;
        logic [5:0] tail;
        logic [5:0] head;
        stop_at = request_count + RAND_REQS;
        phase = 0;
        while (request_count < stop_at)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 3)
                write_vertex_count(6'd32);
            else if (sel == 3)
                write_vertex_count(6'($urandom_range(33, 63)));
            else if (sel == 4 && phase > 2)
                write_vertex_count(6'd0);
            else
                write_vertex_count(6'($urandom_range(1, 12)));
            n_eff = (vertex_count_reg > MAX_V) ? MAX_V : int'(vertex_count_reg);
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            send_request(OP_CLEAR, 6'($urandom()), 6'($urandom()));
            edges = (n_eff == 0) ? 3 : $urandom_range(2, (n_eff > 9) ? 20 : 2 * n_eff + 2);
            for (int e = 0; e < edges; e++)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    send_request(OP_UNUSED, 6'($urandom()), 6'($urandom()));
                else if (sel == 1 || n_eff == 0)
                    send_request(OP_ADD, 6'($urandom()), 6'($urandom()));
                else
                begin
                    tail = 6'($urandom_range(1, n_eff));
                    if (sel < 6)
                        head = (tail == n_eff) ? 6'd1 : tail + 6'd1;
                    else if (sel == 6)
                        head = 6'($urandom_range(1, MAX_V));
                    else
                        head = 6'($urandom_range(1, n_eff));
                    send_request(OP_ADD, tail, head);
                end
                if (e == edges / 2 && (phase == 1 || $urandom_range(0, 3) == 0))
                    drain(0);
            end
            for (int k = $urandom_range(1, 2); k > 0; k--)
            begin
                if ($urandom_range(0, 7) == 0 || n_eff == 0)
                    send_request(OP_RUN, 6'($urandom()), 6'($urandom()));
                else
                    send_request(OP_RUN, 6'($urandom_range(1, n_eff)), 6'($urandom()));
                if ($urandom_range(0, 3) == 0)
                    drain(0);
            end
            phase++;
        end
    endtask

    initial
    begin
        for (int v = 1; v <= MAX_V; v++)
            edge_rows[v] = '0;
        vertex_count_reg = 6'd32;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_vertex_counts();
        test_random_graphs();
        drain(SETTLE);
        $display("tb: sent %0d requests including %0d searches over %0d vertex-count settings",
                 request_count, search_count, setting_count);
        $display("tb: checked %0d per-vertex results, %0d errors", results_checked,
                 error_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb: timeout with %0d results outstanding", pending_results.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/dfs_te_pkg.sv
rtl/core/dfs_te_ctrl.sv
rtl/core/dfs_te_dp.sv
rtl/core/dfs_timestamp_engine.sv
sim/tb.sv
